// ----- rtl/pure_pursuit_steering_top_assert.svh -----
// Assertion macros used by the pure pursuit steering controller.
`ifndef PURE_PURSUIT_STEERING_TOP_ASSERT_SVH
`define PURE_PURSUIT_STEERING_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PPS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pps_pkg.sv -----
// Shared types and constants of the pure pursuit steering block.
`default_nettype none
package pps_pkg;
    localparam int unsigned AtanEntries = 24;

    // Input command codes.
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_STEP   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LOOKAHEAD = 2'd0;
    localparam logic [1:0] CFG_SPEED     = 2'd1;
    localparam logic [1:0] CFG_TOLERANCE = 2'd2;

    localparam logic [23:0] LOOKAHEAD_RST = 24'd26214;
    localparam logic [19:0] SPEED_RST     = 20'd13107;
    localparam logic [19:0] TOLERANCE_RST = 20'd3277;
    localparam logic signed [33:0] SIN_X0 = 34'sd652032874;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_pose;   // capture pose, start scan
        logic scan_issue;  // read waypoint at scan index
        logic scan_eval;   // distance of the returned waypoint
        logic sel_issue;   // read the selected waypoint
        logic sel_eval;    // capture dx, dy and distance
        logic mul_step;    // one step of the sequential squaring
        logic sqrt_init;
        logic sqrt_step;
        logic atan_init;
        logic atan_step;
        logic sin_init;
        logic sin_step;
        logic num_step;
        logic div_init;
        logic div_step;
        logic out_load;
        logic out_goal;
    } t_ctl;

    // Status from the datapath.
    typedef struct packed {
        logic hit;      // current scan waypoint is at or beyond lookahead
        logic goal;     // selected target within tolerance
        logic mul_done;
        logic sqrt_done;
        logic cordic_done;
        logic div_done;
    } t_sts;

    // Arctangent of 2^-i in 32 bit binary angle units.
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0: v = 32'd536870912;  5'd1: v = 32'd316933406;
            5'd2: v = 32'd167458907;  5'd3: v = 32'd85004756;
            5'd4: v = 32'd42667331;   5'd5: v = 32'd21354465;
            5'd6: v = 32'd10680862;   5'd7: v = 32'd5340245;
            5'd8: v = 32'd2670163;    5'd9: v = 32'd1335087;
            5'd10: v = 32'd667544;    5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;    5'd13: v = 32'd83443;
            5'd14: v = 32'd41721;     5'd15: v = 32'd20860;
            5'd16: v = 32'd10430;     5'd17: v = 32'd5215;
            5'd18: v = 32'd2607;      5'd19: v = 32'd1303;
            5'd20: v = 32'd651;       5'd21: v = 32'd325;
            5'd22: v = 32'd162;       5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ----- rtl/pps_ram.sv -----
// Generic single port RAM with registered read.
`default_nettype none
module pps_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // One access per cycle: a write, if enabled, and a read of the same address, which returns the old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ----- rtl/pps_datapath.sv -----
// Datapath: waypoint memories, distance, square root, CORDIC and divider.
`default_nettype none
module pps_datapath #(
    parameter int unsigned MAX_WAYPOINTS     = 64,
    parameter int unsigned CORDIC_ITERATIONS = 16
) (
    input  wire logic                             i_clk,
    input  wire pps_pkg::t_ctl                    i_ctl,
    input  wire logic                             i_wr_en,
    input  wire logic [$clog2(MAX_WAYPOINTS)-1:0] i_addr,
    input  wire logic signed [31:0]               i_pos_x,
    input  wire logic signed [31:0]               i_pos_y,
    input  wire logic signed [15:0]               i_heading,
    input  wire logic [23:0]                      i_lookahead,
    input  wire logic [19:0]                      i_speed,
    input  wire logic [19:0]                      i_tolerance,
    output pps_pkg::t_sts                         o_sts,
    output logic signed [31:0]                    o_rate
);
    import pps_pkg::*;

    localparam int unsigned AW = $clog2(MAX_WAYPOINTS);
    localparam int unsigned NIT = (CORDIC_ITERATIONS < AtanEntries) ?
                                  CORDIC_ITERATIONS : AtanEntries;
    localparam logic [4:0] LAST_IT = 5'(NIT - 1);

    logic [31:0] w_rx, w_ry;

    pps_ram #(.WIDTH(32), .DEPTH(MAX_WAYPOINTS)) u_ram_x (
        .i_clk(i_clk), .i_we(i_wr_en), .i_addr(i_addr),
        .i_wdata(i_pos_x), .o_rdata(w_rx));
    pps_ram #(.WIDTH(32), .DEPTH(MAX_WAYPOINTS)) u_ram_y (
        .i_clk(i_clk), .i_we(i_wr_en), .i_addr(i_addr),
        .i_wdata(i_pos_y), .o_rdata(w_ry));

    logic signed [31:0] r_px, r_py;
    logic [31:0]        r_hd;
    logic signed [32:0] r_dx, r_dy;
    logic [32:0]        r_ax, r_ay;
    // sequential squaring: each 33-bit operand split into a 16-bit low and a 17-bit high part
    logic [2:0]         r_mph;
    logic [65:0]        r_acc;
    logic [47:0]        r_l2;
    logic [39:0]        r_t2;

    // Differences of the waypoint that just came out of memory.
    logic signed [32:0] w_ex, w_ey;
    logic [32:0]        w_aex, w_aey;
    assign w_ex  = 33'(signed'(w_rx)) - 33'(r_px);
    assign w_ey  = 33'(signed'(w_ry)) - 33'(r_py);
    assign w_aex = w_ex[32] ? 33'(-w_ex) : 33'(w_ex);
    assign w_aey = w_ey[32] ? 33'(-w_ey) : 33'(w_ey);

    // Partial product select for the squaring sequence.
    logic [16:0] w_ma, w_mb;
    logic [33:0] w_pp;
    logic [65:0] w_ppsh;
    always_comb begin
        w_ma = 17'd0; w_mb = 17'd0; w_ppsh = 66'd0;
        case (r_mph)
            3'd0: begin w_ma = {1'b0, r_ax[15:0]}; w_mb = {1'b0, r_ax[15:0]}; end
            3'd1: begin w_ma = {1'b0, r_ax[15:0]}; w_mb = r_ax[32:16]; end
            3'd2: begin w_ma = r_ax[32:16]; w_mb = r_ax[32:16]; end
            3'd3: begin w_ma = {1'b0, r_ay[15:0]}; w_mb = {1'b0, r_ay[15:0]}; end
            3'd4: begin w_ma = {1'b0, r_ay[15:0]}; w_mb = r_ay[32:16]; end
            3'd5: begin w_ma = r_ay[32:16]; w_mb = r_ay[32:16]; end
            default: begin w_ma = 17'd0; w_mb = 17'd0; end
        endcase
        w_pp = w_ma * w_mb;
        case (r_mph)
            3'd0, 3'd3: w_ppsh = 66'(w_pp);
            3'd1, 3'd4: w_ppsh = 66'(w_pp) << 17;
            3'd2, 3'd5: w_ppsh = 66'(w_pp) << 32;
            default:    w_ppsh = 66'd0;
        endcase
    end

    // Distance tests on the finished sum, valid in the cycle that the sum completes.
    logic w_hit, w_goal;
    assign w_hit  = r_acc[64] || (r_acc[63:0] >= 64'(r_l2));
    assign w_goal = !r_acc[64] && (r_acc[63:0] < 64'(r_t2) || r_acc[63:0] == 64'd0);

    // Square root: one result bit per cycle on a 66 bit radicand.
    logic [65:0] r_rad;
    logic [33:0] r_root;
    logic [35:0] r_rem;
    logic [5:0]  r_sq_cnt;
    logic        r_carry;
    logic [35:0] w_trial;
    assign w_trial = {r_rem[33:0], r_rad[65:64]} - {r_root, 2'b01};

    // CORDIC registers shared by atan2 and sin.
    logic signed [35:0] r_cx, r_cy;
    logic [31:0]        r_cz;
    logic signed [32:0] r_ca;
    logic [4:0]         r_it;
    logic               r_mode_sin;
    logic signed [35:0] w_xs, w_ys;
    logic [31:0]        w_at;
    logic [31:0]        w_alpha;
    logic signed [32:0] w_asx;
    assign w_xs = r_cx >>> r_it;
    assign w_ys = r_cy >>> r_it;
    assign w_at = atan_turn(r_it);
    assign w_alpha = r_cz - {r_hd[15:0], 16'd0};
    always_comb begin
        if ($signed(w_alpha) > 32'sh40000000 || $signed(w_alpha) < -32'sh40000000) begin
            w_asx = 33'(signed'(32'h80000000 - w_alpha));
        end else begin
            w_asx = 33'(signed'(w_alpha));
        end
    end

    // Numerator 2*v*|sin|, multiplied in one 20x31 step.
    logic [30:0] r_asn;
    logic        r_neg;
    logic [48:0] r_den;
    logic [52:0] r_rmd;
    logic [51:0] r_q;
    logic [5:0]  r_dcnt;
    logic [52:0] w_dtry;
    assign w_dtry = {r_rmd[51:0], r_q[51]} - 53'(r_den);

    logic [32:0] r_ld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_pose) begin
            r_px <= i_pos_x;
            r_py <= i_pos_y;
            r_hd <= 32'(unsigned'(i_heading));
            r_l2 <= i_lookahead * i_lookahead;
            r_t2 <= i_tolerance * i_tolerance;
        end
        if (i_ctl.scan_eval || i_ctl.sel_eval) begin
            r_dx  <= w_ex;
            r_dy  <= w_ey;
            r_ax  <= w_aex;
            r_ay  <= w_aey;
            r_mph <= 3'd0;
            r_acc <= 66'd0;
        end
        if (i_ctl.mul_step && r_mph != 3'd6) begin
            r_acc <= r_acc + w_ppsh;
            r_mph <= r_mph + 3'd1;
        end
        // Square root sequencing.
        if (i_ctl.sqrt_init) begin
            r_carry  <= r_acc[64];
            r_rad    <= r_acc[64] ? 66'(r_acc[64:2]) : {2'b00, r_acc[63:0]};
            r_root   <= 34'd0;
            r_rem    <= 36'd0;
            r_sq_cnt <= 6'd33;
        end else if (i_ctl.sqrt_step && r_sq_cnt != 6'd0) begin
            r_rad    <= {r_rad[63:0], 2'b00};
            r_sq_cnt <= r_sq_cnt - 6'd1;
            if (!w_trial[35]) begin
                r_rem  <= w_trial;
                r_root <= {r_root[32:0], 1'b1};
            end else begin
                r_rem  <= {r_rem[33:0], r_rad[65:64]};
                r_root <= {r_root[32:0], 1'b0};
            end
        end
        if (i_ctl.sqrt_step && r_sq_cnt == 6'd0) begin
            r_ld <= r_carry ? {r_root[31:0], 1'b0} : r_root[32:0];
        end
        // CORDIC.
        if (i_ctl.atan_init) begin
            r_mode_sin <= 1'b0;
            r_it <= 5'd0;
            r_cx <= r_dx[32] ? 36'(-r_dx) : 36'(r_dx);
            r_cy <= r_dx[32] ? 36'(-r_dy) : 36'(r_dy);
            r_cz <= r_dx[32] ? 32'h80000000 : 32'd0;
        end else if (i_ctl.sin_init) begin
            r_mode_sin <= 1'b1;
            r_it <= 5'd0;
            r_cx <= 36'(SIN_X0);
            r_cy <= 36'sd0;
            r_ca <= w_asx;
        end else if ((i_ctl.atan_step || i_ctl.sin_step) && !o_sts.cordic_done) begin
            r_it <= r_it + 5'd1;
            if (!r_mode_sin) begin
                if (!r_cy[35]) begin
                    r_cx <= r_cx + w_ys; r_cy <= r_cy - w_xs; r_cz <= r_cz + w_at;
                end else begin
                    r_cx <= r_cx - w_ys; r_cy <= r_cy + w_xs; r_cz <= r_cz - w_at;
                end
            end else begin
                if (!r_ca[32]) begin
                    r_cx <= r_cx - w_ys; r_cy <= r_cy + w_xs;
                    r_ca <= r_ca - 33'(w_at);
                end else begin
                    r_cx <= r_cx + w_ys; r_cy <= r_cy - w_xs;
                    r_ca <= r_ca + 33'(w_at);
                end
            end
        end
        if (i_ctl.num_step) begin
            r_neg <= r_cy[35];
            r_asn <= r_cy[35] ? 31'(-r_cy) : r_cy[30:0];
        end
        // Restoring division, one quotient bit per cycle.
        if (i_ctl.div_init) begin
            r_q    <= {51'(i_speed) * 51'(r_asn), 1'b0};
            r_den  <= 49'({r_ld, 14'd0});
            r_rmd  <= 53'd0;
            r_dcnt <= 6'd52;
        end else if (i_ctl.div_step && r_dcnt != 6'd0) begin
            r_dcnt <= r_dcnt - 6'd1;
            if (!w_dtry[52]) begin
                r_rmd <= w_dtry;
                r_q   <= {r_q[50:0], 1'b1};
            end else begin
                r_rmd <= {r_rmd[51:0], r_q[51]};
                r_q   <= {r_q[50:0], 1'b0};
            end
        end
        if (i_ctl.out_goal) begin
            o_rate <= 32'sd0;
        end else if (i_ctl.out_load) begin
            if (!r_neg) begin
                o_rate <= (r_q > 52'h7FFFFFFF) ? 32'sh7FFFFFFF : r_q[31:0];
            end else begin
                o_rate <= (r_q > 52'h80000000) ? 32'h80000000 : 32'(-r_q[31:0]);
            end
        end
    end

    always_comb begin
        o_sts.hit         = w_hit;
        o_sts.goal        = w_goal;
        o_sts.mul_done    = (r_mph == 3'd6);
        o_sts.sqrt_done   = (r_sq_cnt == 6'd0);
        o_sts.cordic_done = (r_it > LAST_IT);
        o_sts.div_done    = (r_dcnt == 6'd0);
    end

    logic w_unused;
    assign w_unused = ^{r_acc[65], r_hd[31:16], i_ctl.scan_issue, i_ctl.sel_issue, AW[0]};
endmodule
`default_nettype wire

// ----- rtl/pps_ctrl.sv -----
// Controller: handshakes, waypoint bookkeeping and the control step sequence.
`default_nettype none
module pps_ctrl #(
    parameter int unsigned MAX_WAYPOINTS = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [1:0]                       i_cmd,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    input  wire pps_pkg::t_sts                    i_sts,
    output pps_pkg::t_ctl                         o_ctl,
    output logic                                  o_wr_en,
    output logic [$clog2(MAX_WAYPOINTS)-1:0]      o_addr,
    output logic                                  o_goal,
    output logic                                  o_overflow
);
    import pps_pkg::*;

    localparam int unsigned AW = $clog2(MAX_WAYPOINTS);
    localparam int unsigned CW = $clog2(MAX_WAYPOINTS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_WAIT, S_SCAN_MUL, S_SEL_RD, S_SEL_WAIT,
        S_SEL_MUL, S_SQRT, S_ATAN, S_SIN, S_NUM, S_DIV, S_OUT, S_HOLD
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_idx;
    logic            r_ovf;
    logic            r_goal;
    logic            w_in_xfer;
    t_cmd            w_cmd;

    assign w_cmd     = t_cmd'(i_cmd);
    assign o_stall   = (r_state != S_IDLE);
    assign w_in_xfer = i_valid && !o_stall;
    assign o_overflow = r_ovf;
    assign o_goal     = r_goal;

    // Write when an append transfer fits; otherwise address the scan.
    assign o_wr_en = w_in_xfer && w_cmd == CMD_APPEND && r_count < CW'(MAX_WAYPOINTS);
    assign o_addr  = w_in_xfer ? r_count[AW-1:0] : r_idx[AW-1:0];

    always_comb begin
        o_ctl = '0;
        o_ctl.load_pose = w_in_xfer && w_cmd == CMD_STEP;
        unique case (r_state)
            S_SCAN_WAIT: o_ctl.scan_eval = 1'b1;
            S_SCAN_MUL:  o_ctl.mul_step  = 1'b1;
            S_SEL_WAIT:  o_ctl.sel_eval  = 1'b1;
            S_SEL_MUL:   begin
                o_ctl.mul_step = 1'b1;
                o_ctl.sqrt_init = i_sts.mul_done;
            end
            S_SQRT: begin
                o_ctl.sqrt_step = 1'b1;
                o_ctl.atan_init = i_sts.sqrt_done;
            end
            S_ATAN: begin
                o_ctl.atan_step = 1'b1;
                o_ctl.sin_init  = i_sts.cordic_done;
            end
            S_SIN:  o_ctl.sin_step = 1'b1;
            S_NUM:  o_ctl.num_step = 1'b1;
            S_DIV:  begin
                o_ctl.div_step = 1'b1;
                o_ctl.out_load = i_sts.div_done;
            end
            S_SCAN_RD: o_ctl.scan_issue = 1'b1;
            S_SEL_RD:  o_ctl.sel_issue  = 1'b1;
            S_OUT:     o_ctl.div_init   = 1'b1;
            default: ;
        endcase
        if (r_state == S_SEL_MUL && i_sts.mul_done && i_sts.goal) begin
            o_ctl.out_goal  = 1'b1;
            o_ctl.sqrt_init = 1'b0;
        end
    end

    // State, list bookkeeping and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_ovf   <= 1'b0;
            r_goal  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        unique case (w_cmd)
                            CMD_CLEAR: r_count <= '0;
                            CMD_APPEND: begin
                                if (r_count < CW'(MAX_WAYPOINTS)) begin
                                    r_count <= r_count + 1'b1;
                                end else begin
                                    r_ovf <= 1'b1;
                                end
                            end
                            CMD_STEP: begin
                                if (r_count != '0) begin
                                    r_idx   <= '0;
                                    r_state <= S_SCAN_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN_RD:   r_state <= S_SCAN_WAIT;
                S_SCAN_WAIT: r_state <= S_SCAN_MUL;
                S_SCAN_MUL: begin
                    if (i_sts.mul_done) begin
                        if (i_sts.hit || r_idx == r_count - 1'b1) begin
                            r_state <= S_SEL_RD;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_SCAN_RD;
                        end
                    end
                end
                S_SEL_RD:   r_state <= S_SEL_WAIT;
                S_SEL_WAIT: r_state <= S_SEL_MUL;
                S_SEL_MUL: begin
                    if (i_sts.mul_done) begin
                        if (i_sts.goal) begin
                            r_goal  <= 1'b1;
                            o_valid <= 1'b1;
                            r_state <= S_HOLD;
                        end else begin
                            r_goal  <= 1'b0;
                            r_state <= S_SQRT;
                        end
                    end
                end
                S_SQRT: if (i_sts.sqrt_done) r_state <= S_ATAN;
                S_ATAN: if (i_sts.cordic_done) r_state <= S_SIN;
                S_SIN:  if (i_sts.cordic_done) r_state <= S_NUM;
                S_NUM:  r_state <= S_OUT;
                S_OUT:  r_state <= S_DIV;
                S_DIV: begin
                    if (i_sts.div_done) begin
                        o_valid <= 1'b1;
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `include "pure_pursuit_steering_top_assert.svh"

    `PPS_ASSERT_IMPL(a_cnt_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_WAYPOINTS), "count overflow")
    `PPS_ASSERT_IMPL(a_valid_hold, i_clk, i_rst_n, o_valid, r_state == S_HOLD, "valid outside hold")
    `PPS_ASSERT_IMPL(a_scan_bound, i_clk, i_rst_n, r_state == S_SCAN_RD, r_idx < r_count, "scan past list")
    `PPS_ASSERT_NEXT(a_ovf_sticky, i_clk, i_rst_n, r_ovf, r_ovf, "overflow flag dropped")
endmodule
`default_nettype wire

// ----- rtl/pure_pursuit_steering_top.sv -----
// Top level of the pure pursuit steering block.
//
//  Channel  Direction  Handshake           Payload
//  input    in         i_valid / o_stall   cmd, pos_x, pos_y, heading
//  result   out        o_valid / i_stall   linear_speed, angular_rate, goal_reached, flags
//  config   in         i_cfg_we            i_cfg_index, i_cfg_data
//
// Clear and append complete with their transfer. A control step on a non-empty list
// scans the waypoints, reading each from memory and squaring its distance in the shared
// squaring unit, then reads and squares the selected target; it raises its result there
// when the goal is reached, and otherwise after the root, the CORDIC and the divider.
// Reset is synchronous and active low; the waypoint memories are not cleared.
// The input stalls while a step is in work or its result waits to be taken.
`default_nettype none
module pure_pursuit_steering_top #(
    parameter int unsigned MAX_WAYPOINTS     = 64,
    parameter int unsigned CORDIC_ITERATIONS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_cmd,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [15:0] i_heading,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [19:0]             o_linear_speed,
    output logic signed [31:0]      o_angular_rate,
    output logic                    o_goal_reached,
    output logic                    o_list_overflow,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [23:0]        i_cfg_data
);
    import pps_pkg::*;

    logic [23:0] r_lookahead;
    logic [19:0] r_speed;
    logic [19:0] r_tolerance;
    t_ctl        w_ctl;
    t_sts        w_sts;
    logic        w_wr_en;
    logic [$clog2(MAX_WAYPOINTS)-1:0] w_addr;
    logic        w_goal;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lookahead <= LOOKAHEAD_RST;
            r_speed     <= SPEED_RST;
            r_tolerance <= TOLERANCE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LOOKAHEAD: r_lookahead <= i_cfg_data;
                CFG_SPEED:     r_speed     <= i_cfg_data[19:0];
                CFG_TOLERANCE: r_tolerance <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    pps_ctrl #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_cmd(i_cmd), .o_valid(o_valid), .i_stall(i_stall), .i_sts(w_sts),
        .o_ctl(w_ctl), .o_wr_en(w_wr_en), .o_addr(w_addr), .o_goal(w_goal),
        .o_overflow(o_list_overflow));

    pps_datapath #(
        .MAX_WAYPOINTS(MAX_WAYPOINTS), .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_dp (
        .i_clk(i_clk), .i_ctl(w_ctl), .i_wr_en(w_wr_en), .i_addr(w_addr),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_heading(i_heading),
        .i_lookahead(r_lookahead), .i_speed(r_speed), .i_tolerance(r_tolerance),
        .o_sts(w_sts), .o_rate(o_angular_rate));

    // Speed is zero when the goal is reached.
    assign o_goal_reached = w_goal;
    assign o_linear_speed = w_goal ? 20'd0 : r_speed;
endmodule
`default_nettype wire
